// ----- sv/rbps_pkg.sv -----
// ----------------------------------------------------------------------------
// Range-bin peak search package
// Shared widths, register indexes, reset values and item types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rbps_pkg;

  localparam int SampW  = 16;
  localparam int ChirpW = 6;
  localparam int BinW   = 9;
  localparam int PowW   = 32;
  localparam int RegIdxW = 1;

  // Configuration register indexes
  localparam logic [RegIdxW-1:0] RegMinPower  = 1'b0;
  localparam logic [RegIdxW-1:0] RegGuardBins = 1'b1;

  localparam logic [PowW-1:0] MinPowerRst  = 32'd4000000;
  localparam logic [BinW-1:0] GuardBinsRst = 9'd6;

  typedef struct packed {
    logic [PowW-1:0] min_power;
    logic [BinW-1:0] guard_bins;
  } cfg_t;

  // Classified sample handed from the front to the back
  typedef struct packed {
    logic [ChirpW-1:0] chirp;
    logic [BinW-1:0]   bin;
    logic              ant;
    logic              last;
    logic [PowW-1:0]   power;
    logic              qual;    // above threshold and beyond the guard
  } item_t;

  // Per-chirp running best
  typedef struct packed {
    logic [PowW-1:0] power;
    logic [BinW-1:0] bin;
  } best_t;

  typedef struct packed {
    logic [ChirpW-1:0] chirp;
    logic              ant;
    logic [BinW-1:0]   bin;
    logic [PowW-1:0]   power;
    logic              found;
  } result_t;

endpackage

`default_nettype wire

// ----- sv/rbps_fifo.sv -----
// ----------------------------------------------------------------------------
// Range-bin peak search queue
// Small first-in first-out buffer built from registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbps_fifo #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wr_data_i,
  input  wire logic             pop_i,
  output logic      [Width-1:0] rd_data_o,
  output logic                  full_o,
  output logic                  empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o    = (count_q == CntW'(Depth));
  assign empty_o   = (count_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

// ----- sv/rbps_front.sv -----
// ----------------------------------------------------------------------------
// Range-bin peak search front end
// Accepts samples, computes squared magnitude and classifies each bin.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbps_front
  import rbps_pkg::*;
#(
  parameter int MaxChirps = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cfg_t              cfg_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [SampW-1:0]  i_sample_i,
  input  wire logic [SampW-1:0]  q_sample_i,
  input  wire logic [ChirpW-1:0] chirp_i,
  input  wire logic [BinW-1:0]   bin_i,
  input  wire logic              ant_i,
  input  wire logic              last_i,
  output logic                   push_o,
  output item_t                  item_o,
  input  wire logic              q_full_i
);

  localparam logic [10:0] ChirpLim = 11'(MaxChirps);

  logic                   en;
  logic                   in_range;
  logic signed [PowW-1:0] i_ext, q_ext;
  logic                   f1_valid_q;
  logic [PowW-1:0]        f1_sq_i_q, f1_sq_q_q;
  logic [ChirpW-1:0]      f1_chirp_q;
  logic [BinW-1:0]        f1_bin_q;
  logic                   f1_ant_q, f1_last_q;
  logic [PowW-1:0]        power;
  logic                   f2_valid_q;
  item_t                  f2_item_q, f2_item_d;

  // Advance the whole front pipeline unless the queue holds back the tail
  assign en         = !f2_valid_q || !q_full_i;
  assign in_ready_o = en;
  assign in_range   = ({5'b0, chirp_i} < ChirpLim);
  assign push_o     = f2_valid_q && !q_full_i;
  assign item_o     = f2_item_q;

  // Sign-extend before squaring so the full product is kept
  assign i_ext = PowW'($signed(i_sample_i));
  assign q_ext = PowW'($signed(q_sample_i));

  assign power = f1_sq_i_q + f1_sq_q_q;

  always_comb begin
    f2_item_d.chirp = f1_chirp_q;
    f2_item_d.bin   = f1_bin_q;
    f2_item_d.ant   = f1_ant_q;
    f2_item_d.last  = f1_last_q;
    f2_item_d.power = power;
    f2_item_d.qual  = (power > cfg_i.min_power) && (f1_bin_q > cfg_i.guard_bins);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
      f2_valid_q <= 1'b0;
    end else if (en) begin
      // Drop samples of chirps beyond the table
      f1_valid_q <= in_valid_i && in_range;
      f2_valid_q <= f1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_sq_i_q  <= i_ext * i_ext;
      f1_sq_q_q  <= q_ext * q_ext;
      f1_chirp_q <= chirp_i;
      f1_bin_q   <= bin_i;
      f1_ant_q   <= ant_i;
      f1_last_q  <= last_i;
      f2_item_q  <= f2_item_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/rbps_back.sv -----
// ----------------------------------------------------------------------------
// Range-bin peak search back end
// Per-chirp read-modify-write of the running best, with result issue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbps_back
  import rbps_pkg::*;
#(
  parameter int MaxChirps = 64
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  q_valid_i,
  input  wire item_t q_item_i,
  output logic       q_pop_o,
  output logic       res_push_o,
  output result_t    res_o,
  input  wire logic  res_full_i
);

  localparam int MemDepth = (MaxChirps < (2 ** ChirpW)) ? MaxChirps : (2 ** ChirpW);
  localparam int AddrW    = (MemDepth > 1) ? $clog2(MemDepth) : 1;

  best_t            mem_q [MemDepth];
  best_t            rd_q;
  logic             s1_valid_q;
  item_t            s1_q;
  logic [AddrW-1:0] s1_addr, pop_addr;
  logic             fwd_valid_q;
  logic [AddrW-1:0] fwd_addr_q;
  best_t            fwd_q;
  best_t            base, upd;
  logic             s1_adv;

  assign s1_addr  = AddrW'(s1_q.chirp);
  assign pop_addr = AddrW'(q_item_i.chirp);

  // Bin zero restarts the entry; otherwise take the latest write if the
  // memory read raced it
  always_comb begin
    if (s1_q.bin == '0) begin
      base = '0;
    end else if (fwd_valid_q && (fwd_addr_q == s1_addr)) begin
      base = fwd_q;
    end else begin
      base = rd_q;
    end
    upd = base;
    if (s1_q.qual && (s1_q.power > base.power)) begin
      upd.power = s1_q.power;
      upd.bin   = s1_q.bin;
    end
  end

  assign s1_adv     = s1_valid_q && (!s1_q.last || !res_full_i);
  assign q_pop_o    = q_valid_i && (!s1_valid_q || s1_adv);
  assign res_push_o = s1_valid_q && s1_q.last && !res_full_i;

  always_comb begin
    res_o.chirp = s1_q.chirp;
    res_o.ant   = s1_q.ant;
    res_o.bin   = upd.bin;
    res_o.power = upd.power;
    res_o.found = (upd.power != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        fwd_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_q <= q_item_i;
      rd_q <= mem_q[pop_addr];
    end
    if (s1_adv) begin
      mem_q[s1_addr] <= upd;
      fwd_addr_q     <= s1_addr;
      fwd_q          <= upd;
    end
  end

  // A reported peak always sits on a nonzero bin
  a_found_bin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o && res_o.found |-> res_o.bin != '0)
    else $error("peak reported on bin zero");

  // A held stage keeps its item
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_q))
    else $error("stalled stage lost its item");

  // The running best never drops below its old value except on restart
  a_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && (s1_q.bin != '0) |-> upd.power >= base.power)
    else $error("running best decreased");

  // Results leave only with a write-back of the same item
  a_push_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> s1_adv)
    else $error("result issued without write-back");

endmodule

`default_nettype wire

// ----- sv/range_bin_peak_search.sv -----
// ----------------------------------------------------------------------------
// Range-bin peak search
// Thresholded per-chirp argmax over range-FFT samples.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the s_axis channel, one transfer per cycle while
//   s_axis_tready is high, in memory order (bin-major, chirps interleaved).
//   tlast marks the final bin of a chirp; that transfer yields one result on
//   m_axis carrying the chirp's strongest qualifying bin, its squared power
//   and a found flag. Samples whose chirp lies at or beyond MAX_CHIRPS are
//   dropped without result. From the last-bin transfer to m_axis_tvalid a
//   result passes two front stages (squares, then sum and threshold), the
//   queue, the table read, and the write-back that loads the output buffer.
//   Throughput is one sample per cycle unless back-pressure stalls it; the
//   single read-modify-write per sample on the chirp table sets it, with the
//   latest write forwarded when consecutive samples hit the same chirp. A
//   stalled receiver first fills the two-entry output buffer, then the back
//   end halts, then the four-entry queue fills and s_axis_tready drops. Reset
//   restores min_power 4000000 and guard_bins 6 and empties all pipelines;
//   the chirp table is not cleared, so each chirp must see bin 0 before its
//   result is meaningful. cfg_we_i writes register cfg_idx_i (0 min_power,
//   1 guard_bins); the user must write only while idle; it is not enforced.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module range_bin_peak_search
  import rbps_pkg::*;
#(
  parameter int MAX_CHIRPS = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration write port
  input  wire logic               cfg_we_i,
  input  wire logic [RegIdxW-1:0] cfg_idx_i,
  input  wire logic [PowW-1:0]    cfg_data_i,
  // sample stream
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [47:0]        s_axis_tdata,  // i_sample, q_sample, chirp_index,
                                                 // bin_index, zero pad
  input  wire logic               s_axis_tuser,  // antenna_index
  input  wire logic               s_axis_tlast,  // last_bin
  // result stream
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [47:0]             m_axis_tdata,  // out_chirp, peak_bin, peak_power,
                                                 // found
  output logic                    m_axis_tuser   // out_antenna
);

  localparam int QueueDepth = 4;
  localparam int OutDepth   = 2;

  cfg_t    cfg_q;
  logic    q_push, q_pop, q_full, q_empty;
  item_t   q_wr, q_rd;
  logic    res_push, res_full, res_empty;
  result_t res_wr, res_rd;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_power  <= MinPowerRst;
      cfg_q.guard_bins <= GuardBinsRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegMinPower:  cfg_q.min_power  <= cfg_data_i;
        RegGuardBins: cfg_q.guard_bins <= cfg_data_i[BinW-1:0];
        default: ;
      endcase
    end
  end

  rbps_front #(
    .MaxChirps (MAX_CHIRPS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .i_sample_i (s_axis_tdata[15:0]),
    .q_sample_i (s_axis_tdata[31:16]),
    .chirp_i    (s_axis_tdata[37:32]),
    .bin_i      (s_axis_tdata[46:38]),
    .ant_i      (s_axis_tuser),
    .last_i     (s_axis_tlast),
    .push_o     (q_push),
    .item_o     (q_wr),
    .q_full_i   (q_full)
  );

  // Decouple classification from the table update
  rbps_fifo #(
    .Width ($bits(item_t)),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .wr_data_i (q_wr),
    .pop_i     (q_pop),
    .rd_data_o (q_rd),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  rbps_back #(
    .MaxChirps (MAX_CHIRPS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (!q_empty),
    .q_item_i   (q_rd),
    .q_pop_o    (q_pop),
    .res_push_o (res_push),
    .res_o      (res_wr),
    .res_full_i (res_full)
  );

  // Output buffer: hold finished results while the receiver stalls
  rbps_fifo #(
    .Width ($bits(result_t)),
    .Depth (OutDepth)
  ) u_out_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (res_push),
    .wr_data_i (res_wr),
    .pop_i     (m_axis_tready),
    .rd_data_o (res_rd),
    .full_o    (res_full),
    .empty_o   (res_empty)
  );

  assign m_axis_tvalid = !res_empty;
  assign m_axis_tdata  = {res_rd.found, res_rd.power, res_rd.bin, res_rd.chirp};
  assign m_axis_tuser  = res_rd.ant;

endmodule

`default_nettype wire
